/* hdl/bump_frame_allocator_with_holes_assert.svh */
// Assertion macros for the frame allocator checker.
`ifndef BUMP_FRAME_ALLOCATOR_WITH_HOLES_ASSERT_SVH
`define BUMP_FRAME_ALLOCATOR_WITH_HOLES_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define BFA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define BFA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/bfa_pkg.sv */
// Shared types and constants for the bump frame allocator.
`default_nettype none
package bfa_pkg;

  localparam int ADDR_W  = 48;
  localparam int FRAME_W = 36;
  localparam int IDX_W   = 4;
  localparam int CFG_AW  = 3;
  localparam int ST_W    = 2;

  localparam logic [FRAME_W-1:0] FRAME_MAX = {FRAME_W{1'b1}};

  localparam int MAP_ENTRIES_DEF = 16;
  localparam int FRAME_SHIFT_DEF = 12;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_ALLOC = 1'b1;

  localparam logic [ST_W-1:0] ST_GRANT  = 2'd0;
  localparam logic [ST_W-1:0] ST_LOADED = 2'd1;
  localparam logic [ST_W-1:0] ST_OOM    = 2'd2;

  localparam logic [CFG_AW-1:0] REG_START_FRAME    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KERNEL_FIRST   = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KERNEL_LIMIT   = 3'd2;
  localparam logic [CFG_AW-1:0] REG_BOOTINFO_FIRST = 3'd3;
  localparam logic [CFG_AW-1:0] REG_BOOTINFO_LIMIT = 3'd4;
  localparam logic [CFG_AW-1:0] REG_RAMDISK_FIRST  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_RAMDISK_LIMIT  = 3'd6;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] top;
    logic              usable;
  } map_entry_t;

endpackage
`default_nettype wire

/* hdl/bump_frame_allocator_with_holes.sv */
// Top level: monotonic frame allocator over a memory map with reserved holes.
//
// Requests enter on start (taken when busy is low) with action, alloc_bytes and
// the entry_* fields. Each request gives one result on first_frame/status,
// marked by done for exactly one cycle; the receiver cannot stall it.
// A load request writes one map slot (if entry_index is in range) and answers
// "loaded" in the next cycle; busy stays low, so loads can be taken every cycle.
// An allocate request runs a pass loop: overflow check (S_HI), reserved range
// check (S_RSV), then a walk of the map memory one slot per cycle (S_SCAN).
// A reserved range hit skips the walk and goes through S_JUMP, a reserved map
// slot through S_MJUMP and S_JUMP, before the next pass. A grant goes through
// S_GRANT. The earliest result comes from the overflow check; busy is high for
// the whole search, so allocations run one at a time.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect at once and
// are to be made only while idle; the block itself does not enforce this.
// Writing start_frame reloads the pointer.
// Reset clears the registers, the pointer and all slot valid bits; there is
// no clearing pass, so requests are taken the cycle after reset drops.
`default_nettype none
module bump_frame_allocator_with_holes
  import bfa_pkg::*;
#(
  parameter int MAP_ENTRIES = MAP_ENTRIES_DEF,
  parameter int FRAME_SHIFT = FRAME_SHIFT_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               action,
  input  wire logic [ADDR_W-1:0]  alloc_bytes,
  input  wire logic [IDX_W-1:0]   entry_index,
  input  wire logic [ADDR_W-1:0]  entry_start,
  input  wire logic [ADDR_W-1:0]  entry_end,
  input  wire logic               entry_available,
  output logic                    done,
  output logic [FRAME_W-1:0]      first_frame,
  output logic [ST_W-1:0]         status,
  input  wire logic               cfg_we,
  input  wire logic [CFG_AW-1:0]  cfg_addr,
  input  wire logic [FRAME_W-1:0] cfg_wdata
);

  localparam int IW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int CW  = $clog2(MAP_ENTRIES + 1);
  localparam int PW  = $clog2(MAP_ENTRIES + 4);
  localparam int FW  = ADDR_W - FRAME_SHIFT + 1;
  localparam int WW  = ((FW > FRAME_W) ? FW : FRAME_W) + 1;
  localparam int BW  = (ADDR_W > FRAME_W + FRAME_SHIFT) ? ADDR_W : FRAME_W + FRAME_SHIFT;
  localparam int XW  = IW + IDX_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HI    = 4'd1;
  localparam logic [3:0] S_RSV   = 4'd2;
  localparam logic [3:0] S_SCAN  = 4'd3;
  localparam logic [3:0] S_MJUMP = 4'd4;
  localparam logic [3:0] S_JUMP  = 4'd5;
  localparam logic [3:0] S_GRANT = 4'd6;

  logic [3:0]             state;
  logic [FRAME_W-1:0]     next_free;
  logic [FRAME_W-1:0]     rsv_first [3];
  logic [FRAME_W-1:0]     rsv_limit [3];
  logic [MAP_ENTRIES-1:0] map_valid;
  map_entry_t             map_mem [MAP_ENTRIES];

  logic [FRAME_W-1:0] ptr;
  logic [FRAME_W-1:0] hi;
  logic [FW-1:0]      frames;
  logic [FW-1:0]      span;
  logic [BW-1:0]      lo_b;
  logic [BW-1:0]      hi_b;
  logic [FRAME_W-1:0] tgt;
  logic               tgt_ovf;
  logic [ADDR_W-1:0]  top_hold;
  logic [PW-1:0]      pass;
  logic [CW-1:0]      scan_cnt;
  logic               rd_pend;
  logic [IW-1:0]      rd_idx;
  map_entry_t         rd_entry;

  logic               accept;
  logic               load_acc;
  logic               alloc_acc;
  logic [XW-1:0]      widx_full;
  logic               widx_ok;
  logic [FW-1:0]      frames_in;
  logic [WW-1:0]      hi_w;
  logic [WW-1:0]      tgt_w;
  logic [2:0]         rsv_hit;
  logic               entry_hit;
  logic               scan_in_range;
  logic               last_pass;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign load_acc  = accept && (action == ACT_LOAD);
  assign alloc_acc = accept && (action == ACT_ALLOC);

  assign widx_full = XW'(entry_index);
  assign widx_ok   = widx_full < XW'(MAP_ENTRIES);

  assign frames_in = FW'(alloc_bytes >> FRAME_SHIFT) + FW'(|alloc_bytes[FRAME_SHIFT-1:0]);
  assign hi_w      = WW'(ptr) + WW'(span);
  assign tgt_w     = WW'(top_hold >> FRAME_SHIFT) + WW'(|top_hold[FRAME_SHIFT-1:0]);

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rsv_hit[r] = (rsv_first[r] < rsv_limit[r]) && (ptr < rsv_limit[r]) &&
                   (hi > rsv_first[r]);
    end
  end

  assign entry_hit = map_valid[rd_idx] && (BW'(rd_entry.base) <= lo_b) &&
                     (hi_b <= BW'(rd_entry.top));
  assign scan_in_range = scan_cnt < CW'(MAP_ENTRIES);
  assign last_pass     = pass == PW'(MAP_ENTRIES + 3);

  // map memory: one write port for loads, one registered read port for the walk
  always_ff @(posedge clk) begin
    if (load_acc && widx_ok) begin
      map_mem[widx_full[IW-1:0]] <= '{base: entry_start, top: entry_end,
                                      usable: entry_available};
    end
    if (state == S_SCAN && scan_in_range) begin
      rd_entry <= map_mem[scan_cnt[IW-1:0]];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      next_free <= '0;
      map_valid <= '0;
      rd_pend   <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        rsv_first[r] <= '0;
        rsv_limit[r] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_START_FRAME:    next_free    <= cfg_wdata;
          REG_KERNEL_FIRST:   rsv_first[0] <= cfg_wdata;
          REG_KERNEL_LIMIT:   rsv_limit[0] <= cfg_wdata;
          REG_BOOTINFO_FIRST: rsv_first[1] <= cfg_wdata;
          REG_BOOTINFO_LIMIT: rsv_limit[1] <= cfg_wdata;
          REG_RAMDISK_FIRST:  rsv_first[2] <= cfg_wdata;
          REG_RAMDISK_LIMIT:  rsv_limit[2] <= cfg_wdata;
          default: ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (load_acc) begin
            if (widx_ok) begin
              map_valid[widx_full[IW-1:0]] <= 1'b1;
            end
            done <= 1'b1;
          end else if (alloc_acc) begin
            state <= S_HI;
          end
        end
        S_HI: begin
          if (hi_w > WW'(FRAME_MAX)) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_RSV;
          end
        end
        S_RSV: begin
          if (rsv_hit != 3'b000) begin
            state <= S_JUMP;
          end else begin
            rd_pend <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_pend <= scan_in_range;
          if (rd_pend) begin
            if (entry_hit) begin
              state <= rd_entry.usable ? S_GRANT : S_MJUMP;
            end else if (rd_idx == IW'(MAP_ENTRIES - 1)) begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
          end
        end
        S_MJUMP: begin
          state <= S_JUMP;
        end
        S_JUMP: begin
          if (tgt_ovf || tgt <= ptr || last_pass) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            state <= S_HI;
          end
        end
        S_GRANT: begin
          next_free <= FRAME_W'(WW'(ptr) + WW'(frames));
          done      <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ptr    <= next_free;
        frames <= frames_in;
        span   <= (frames_in == '0) ? FW'(1) : frames_in;
        pass   <= '0;
        first_frame <= '0;
        status      <= ST_LOADED;
      end
      S_HI: begin
        hi          <= hi_w[FRAME_W-1:0];
        first_frame <= '0;
        status      <= ST_OOM;
      end
      S_RSV: begin
        lo_b     <= BW'(ptr) << FRAME_SHIFT;
        hi_b     <= BW'(hi) << FRAME_SHIFT;
        scan_cnt <= '0;
        tgt_ovf  <= 1'b0;
        priority if (rsv_hit[0]) tgt <= rsv_limit[0];
        else if (rsv_hit[1])     tgt <= rsv_limit[1];
        else                     tgt <= rsv_limit[2];
      end
      S_SCAN: begin
        if (scan_in_range) begin
          scan_cnt <= scan_cnt + CW'(1);
        end
        rd_idx      <= scan_cnt[IW-1:0];
        top_hold    <= rd_entry.top;
        first_frame <= '0;
        status      <= ST_OOM;
      end
      S_MJUMP: begin
        tgt     <= tgt_w[FRAME_W-1:0];
        tgt_ovf <= tgt_w > WW'(FRAME_MAX);
      end
      S_JUMP: begin
        ptr         <= tgt;
        pass        <= pass + PW'(1);
        first_frame <= '0;
        status      <= ST_OOM;
      end
      S_GRANT: begin
        first_frame <= ptr;
        status      <= ST_GRANT;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/bfa_checker.sv */
// Port-level checker for the frame allocator, bound to the top level.
`default_nettype none
`include "bump_frame_allocator_with_holes_assert.svh"
module bfa_checker
  import bfa_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               action,
  input wire logic               done,
  input wire logic [FRAME_W-1:0] first_frame,
  input wire logic [ST_W-1:0]    status
);

  `BFA_ASSERT_NOW(a_status_code, done, (status == ST_GRANT) || (status == ST_LOADED) || (status == ST_OOM), "bad status code")
  `BFA_ASSERT_NOW(a_zero_frame, done && (status != ST_GRANT), first_frame == '0, "nonzero frame without grant")
  `BFA_ASSERT_NEXT(a_load_result, start && !busy && (action == ACT_LOAD), done && (status == ST_LOADED), "load request gave no loaded result")
  `BFA_ASSERT_NEXT(a_alloc_busy, start && !busy && (action == ACT_ALLOC), busy && !done, "allocate request did not start a search")
  `BFA_ASSERT_NOW(a_done_idle, done, !busy, "result shown while searching")

endmodule

bind bump_frame_allocator_with_holes bfa_checker u_bfa_checker (.*);
`default_nettype wire
